### design/oosp_pkg.sv
// Shared types and constants for the slot pool: slot conditions, request codes,
// controller command and status structs. No dependencies.
package oosp_pkg;

   localparam int ACTION_W = 3;
   localparam int INDEX_W  = 3;
   localparam int TAG_W    = 32;

   typedef enum logic [1:0] {
      COND_EMPTY     = 2'd0,
      COND_WRITING   = 2'd1,
      COND_READY     = 2'd2,
      COND_IN_FLIGHT = 2'd3
   } cond_type;

   localparam logic [ACTION_W-1:0] ACT_RESERVE    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_MARK_READY = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FREE       = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CLAIM      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RESTORE    = 3'd4;

   typedef struct packed {
      logic capture;    // latch the request, rewind the scan pointer
      logic scan_step;  // read the slot at the scan pointer, advance it
      logic fetch;      // read the named slot
      logic finish;     // commit the slot update, load the result register
   } cmd_type;

   typedef struct packed {
      logic in_scan;    // incoming request needs a pass over the pool
      logic in_named;   // incoming request names a slot that exists
      logic scan_last;  // scan pointer sits on the last slot
      logic out_free;   // result register can take a new transaction
   } status_type;

   // a precedes b under wraparound sequence order
   function automatic logic tag_older(input logic [TAG_W-1:0] a,
                                      input logic [TAG_W-1:0] b);
      logic [TAG_W-1:0] diff;
      diff = a - b;
      return diff[TAG_W-1];
   endfunction

endpackage

### design/oosp_chan_if.sv
// Valid/ready channel interfaces for the slot pool request and response.
// Depends on oosp_pkg for the field widths.

interface oosp_req_if;
   logic                          valid;
   logic                          ready;
   logic [oosp_pkg::ACTION_W-1:0] action;
   logic [oosp_pkg::INDEX_W-1:0]  slot_index;
   logic                          retry_later;

   modport source (output valid, action, slot_index, retry_later, input ready);
   modport sink   (input valid, action, slot_index, retry_later, output ready);
endinterface

interface oosp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         granted;
   logic [oosp_pkg::INDEX_W-1:0] chosen_slot;
   logic [oosp_pkg::TAG_W-1:0]   slot_tag;
   logic                         abort_transport;

   modport source (output valid, granted, chosen_slot, slot_tag, abort_transport,
                   input ready);
   modport sink   (input valid, granted, chosen_slot, slot_tag, abort_transport,
                   output ready);
endinterface

### design/overwrite_oldest_slot_pool.sv
// Top level of the slot pool: joins the controller and datapath to the channels.
// Depends on oosp_pkg, oosp_req_if, oosp_rsp_if, oosp_ctrl and oosp_dp.
//
//   channel  dir  handshake    payload
//   req_ch   in   valid/ready  action, slot_index, retry_later
//   rsp_ch   out  valid/ready  granted, chosen_slot, slot_tag, abort_transport
//
// Reserve and claim scan the pool: one registered store read per slot, then the
// tracker stage and the commit. Mark ready, free and restore of a slot that exists
// fetch the named slot, then commit; unknown actions go straight to the commit.
// Reset is synchronous; all slots read as empty with tag zero, counter at zero.
// A result that is not taken holds the commit cycle; a new request is still
// accepted while the previous response waits.
module overwrite_oldest_slot_pool #(
   parameter int SLOT_COUNT = 8
) (
   input logic        clock,
   input logic        reset,
   oosp_req_if.sink   req_ch,
   oosp_rsp_if.source rsp_ch
);
   import oosp_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_ch.ready = req_ready;

   oosp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   oosp_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_ch.action),
      .req_slot_index  (req_ch.slot_index),
      .req_retry_later (req_ch.retry_later),
      .cmd             (cmd),
      .status          (status),
      .rsp             (rsp_ch)
   );

endmodule

### design/oosp_ctrl.sv
// Sequencing state machine for the slot pool: accepts a request, steps the
// datapath through scan, fetch and commit. Depends on oosp_pkg.
module oosp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  oosp_pkg::status_type   status,
   output oosp_pkg::cmd_type      cmd
);
   import oosp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FETCH,
      S_FINISH
   } state_type;

   state_type state_ff;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == S_IDLE) && req_valid;
      cmd.scan_step = (state_ff == S_SCAN);
      cmd.fetch     = (state_ff == S_FETCH);
      cmd.finish    = (state_ff == S_FINISH) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  priority if (status.in_scan) state_ff <= S_SCAN;
                  else if (status.in_named)    state_ff <= S_FETCH;
                  else                         state_ff <= S_FINISH;
               end
            end
            S_SCAN: begin
               if (status.scan_last) state_ff <= S_DRAIN;
            end
            // last read still in flight through the tracker stage
            S_DRAIN: state_ff <= S_FINISH;
            S_FETCH: state_ff <= S_FINISH;
            S_FINISH: begin
               if (status.out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### design/oosp_dp.sv
// Slot pool datapath: condition and tag stores, scan pipeline with oldest/empty
// trackers, sequence counter and the result register. Depends on oosp_pkg.
module oosp_dp #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [oosp_pkg::ACTION_W-1:0]   req_action,
   input  logic [oosp_pkg::INDEX_W-1:0]    req_slot_index,
   input  logic                            req_retry_later,
   input  oosp_pkg::cmd_type               cmd,
   output oosp_pkg::status_type            status,
   oosp_rsp_if.source                      rsp
);
   import oosp_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   // captured request
   logic [ACTION_W-1:0] action_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic                retry_ff;

   // slot stores; per-entry valid bits stand in for the reset value
   cond_type           cond_mem [SLOT_COUNT];
   logic [TAG_W-1:0]   seq_mem  [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] cvld_ff;
   logic [SLOT_COUNT-1:0] svld_ff;
   logic [TAG_W-1:0]   next_tag_ff;

   // read stage
   logic [IDX_W-1:0]   ptr_ff;
   logic               rd_live_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   cond_type           rd_cond_ff;
   logic [TAG_W-1:0]   rd_seq_ff;
   logic               rd_cvld_ff;
   logic               rd_svld_ff;
   logic [IDX_W-1:0]   rd_addr;
   cond_type           rd_cond;
   logic [TAG_W-1:0]   rd_tag;

   // trackers
   logic               empty_found_ff;
   logic [IDX_W-1:0]   empty_idx_ff;
   logic               ready_found_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [TAG_W-1:0]   best_tag_ff;

   // commit decision
   logic               named_ok;
   logic [IDX_W-1:0]   named_idx;
   logic               fin_gnt;
   logic [IDX_W-1:0]   fin_idx;
   logic [TAG_W-1:0]   fin_tag;
   logic               fin_abort;
   logic               wr_en;
   cond_type           wr_cond;
   logic               seq_wr;

   // result register
   logic               rsp_valid_ff;
   logic               gnt_ff;
   logic [INDEX_W-1:0] chosen_ff;
   logic [TAG_W-1:0]   tag_out_ff;
   logic               abort_ff;

   assign named_ok  = int'(index_ff) < SLOT_COUNT;
   assign named_idx = IDX_W'(index_ff);
   assign rd_addr   = cmd.fetch ? named_idx : ptr_ff;
   assign rd_cond   = rd_cvld_ff ? rd_cond_ff : COND_EMPTY;
   assign rd_tag    = rd_svld_ff ? rd_seq_ff : '0;

   always_comb begin
      status           = '0;
      status.in_scan   = (req_action == ACT_RESERVE) || (req_action == ACT_CLAIM);
      status.in_named  = ((req_action == ACT_MARK_READY) || (req_action == ACT_FREE) ||
                          (req_action == ACT_RESTORE)) &&
                         (int'(req_slot_index) < SLOT_COUNT);
      status.scan_last = (ptr_ff == LAST_IDX);
      status.out_free  = !rsp_valid_ff || rsp.ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         index_ff  <= req_slot_index;
         retry_ff  <= req_retry_later;
      end
   end

   // scan pointer and read-stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         rd_live_ff <= 1'b0;
         rd_cvld_ff <= 1'b0;
         rd_svld_ff <= 1'b0;
      end else begin
         rd_live_ff <= cmd.scan_step;
         if (cmd.capture) begin
            ptr_ff <= '0;
         end else if (cmd.scan_step) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
         if (cmd.scan_step || cmd.fetch) begin
            rd_cvld_ff <= cvld_ff[rd_addr];
            rd_svld_ff <= svld_ff[rd_addr];
         end
      end
   end

   // registered store reads
   always_ff @(posedge clock) begin
      if (cmd.scan_step || cmd.fetch) begin
         rd_idx_ff  <= rd_addr;
         rd_cond_ff <= cond_mem[rd_addr];
         rd_seq_ff  <= seq_mem[rd_addr];
      end
   end

   // store writes
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cond_mem[fin_idx] <= wr_cond;
         if (seq_wr) seq_mem[fin_idx] <= next_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cvld_ff     <= '0;
         svld_ff     <= '0;
         next_tag_ff <= '0;
      end else if (wr_en) begin
         cvld_ff[fin_idx] <= 1'b1;
         if (seq_wr) begin
            svld_ff[fin_idx] <= 1'b1;
            next_tag_ff      <= next_tag_ff + 1'b1;
         end
      end
   end

   // first empty and oldest ready; ascending scan so ties keep the lower slot
   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         empty_found_ff <= 1'b0;
         ready_found_ff <= 1'b0;
      end else if (rd_live_ff) begin
         if ((rd_cond == COND_EMPTY) && !empty_found_ff) begin
            empty_found_ff <= 1'b1;
            empty_idx_ff   <= rd_idx_ff;
         end
         if ((rd_cond == COND_READY) &&
             (!ready_found_ff || tag_older(rd_tag, best_tag_ff))) begin
            ready_found_ff <= 1'b1;
            best_idx_ff    <= rd_idx_ff;
            best_tag_ff    <= rd_tag;
         end
      end
   end

   always_comb begin
      fin_gnt   = 1'b0;
      fin_idx   = '0;
      fin_tag   = '0;
      fin_abort = 1'b0;
      wr_en     = 1'b0;
      wr_cond   = COND_EMPTY;
      seq_wr    = 1'b0;
      unique case (action_ff)
         ACT_RESERVE: begin
            if (empty_found_ff || ready_found_ff) begin
               fin_gnt = 1'b1;
               fin_idx = empty_found_ff ? empty_idx_ff : best_idx_ff;
               fin_tag = next_tag_ff;
               wr_en   = cmd.finish;
               wr_cond = COND_WRITING;
               seq_wr  = 1'b1;
            end
         end
         ACT_CLAIM: begin
            if (ready_found_ff) begin
               fin_gnt = 1'b1;
               fin_idx = best_idx_ff;
               fin_tag = best_tag_ff;
               wr_en   = cmd.finish;
               wr_cond = COND_IN_FLIGHT;
            end
         end
         ACT_MARK_READY, ACT_FREE, ACT_RESTORE: begin
            if (named_ok) begin
               fin_gnt   = 1'b1;
               fin_idx   = named_idx;
               fin_tag   = rd_tag;
               wr_en     = cmd.finish;
               wr_cond   = (action_ff == ACT_FREE) ? COND_EMPTY : COND_READY;
               fin_abort = (action_ff == ACT_RESTORE) && !retry_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         gnt_ff     <= fin_gnt;
         chosen_ff  <= INDEX_W'(fin_idx);
         tag_out_ff <= fin_tag;
         abort_ff   <= fin_abort;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.granted         = gnt_ff;
   assign rsp.chosen_slot     = chosen_ff;
   assign rsp.slot_tag        = tag_out_ff;
   assign rsp.abort_transport = abort_ff;

   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp.ready))
      else $error("commit while result register still held");

   a_refused_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !gnt_ff) |-> (!abort_ff && (tag_out_ff == '0)))
      else $error("refused transaction carries a tag or abort");

   a_tag_advances: assert property (@(posedge clock) disable iff (reset)
      (wr_en && seq_wr) |=> (next_tag_ff == $past(next_tag_ff) + 1'b1))
      else $error("sequence counter did not advance on reserve");

   a_no_scan_at_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rd_live_ff && !cmd.scan_step))
      else $error("commit while scan still in progress");

endmodule

### tb/oosp_checker.sv
// Scoreboard for the slot pool: watches the request and response channels,
// predicts each response from its own copy of the pool and compares.
// Depends on oosp_pkg, oosp_req_if and oosp_rsp_if.
`timescale 1ns / 100ps

module oosp_checker #(
   parameter int SLOT_COUNT = 8
) (
   input  logic clock,
   input  logic reset,
   oosp_req_if  req_ch,
   oosp_rsp_if  rsp_ch,
   output int   pending,
   output int   fail_count,
   output int   checked,
   output int   overwrites,
   output int   refusals
);
   import oosp_pkg::*;

   typedef struct packed {
      logic               granted;
      logic [INDEX_W-1:0] slot;
      logic [TAG_W-1:0]   tag;
      logic               abort;
   } pool_result_type;

   cond_type         slot_cond [SLOT_COUNT];
   logic [TAG_W-1:0] slot_seq  [SLOT_COUNT];
   logic [TAG_W-1:0] tag_counter;

   pool_result_type expected_rsp_q[$];
   int mismatches, rsp_seen, overwrite_cnt, refusal_cnt;

   assign fail_count = mismatches;
   assign checked    = rsp_seen;
   assign overwrites = overwrite_cnt;
   assign refusals   = refusal_cnt;

   // wraparound order: a precedes b when the difference has its top bit set
   function automatic logic seq_precedes(input logic [TAG_W-1:0] a,
                                         input logic [TAG_W-1:0] b);
      logic [TAG_W-1:0] delta;
      delta = a - b;
      return delta[TAG_W-1];
   endfunction

   function automatic int oldest_ready_slot();
      int pick;
      pick = -1;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slot_cond[i] == COND_READY &&
             (pick < 0 || seq_precedes(slot_seq[i], slot_seq[pick])))
            pick = i;
      end
      return pick;
   endfunction

   // updates the pool copy and returns the response the request should give
   function automatic pool_result_type predict_request(input logic [ACTION_W-1:0] act,
                                                       input logic [INDEX_W-1:0]  idx,
                                                       input logic                retry);
      pool_result_type r;
      int pick;
      r = '0;
      pick = -1;
      case (act)
         ACT_RESERVE: begin
            for (int i = 0; i < SLOT_COUNT; i++)
               if (pick < 0 && slot_cond[i] == COND_EMPTY) pick = i;
            if (pick < 0) begin
               pick = oldest_ready_slot();
               if (pick >= 0) overwrite_cnt++;
            end
            if (pick >= 0) begin
               slot_cond[pick] = COND_WRITING;
               slot_seq[pick]  = tag_counter;
               tag_counter     = tag_counter + 1;
            end else begin
               refusal_cnt++;
            end
         end
         ACT_CLAIM: begin
            pick = oldest_ready_slot();
            if (pick >= 0) slot_cond[pick] = COND_IN_FLIGHT;
            else refusal_cnt++;
         end
         ACT_MARK_READY, ACT_FREE, ACT_RESTORE: begin
            if (int'(idx) < SLOT_COUNT) begin
               pick = int'(idx);
               slot_cond[pick] = (act == ACT_FREE) ? COND_EMPTY : COND_READY;
               if (act == ACT_RESTORE && !retry) r.abort = 1'b1;
            end
         end
         default: ;
      endcase
      if (pick >= 0) begin
         r.granted = 1'b1;
         r.slot    = pick[INDEX_W-1:0];
         r.tag     = slot_seq[pick];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      pool_result_type want, got;
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_cond[i] = COND_EMPTY;
            slot_seq[i]  = '0;
         end
         tag_counter = '0;
         expected_rsp_q.delete();
      end else begin
         // a response can never belong to a request accepted at the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.granted, rsp_ch.chosen_slot, rsp_ch.slot_tag,
                    rsp_ch.abort_transport};
            rsp_seen++;
            if (expected_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: response with nothing outstanding:", $realtime);
                  $display("  granted %0b slot %0d tag %0h abort %0b",
                           got.granted, got.slot, got.tag, got.abort);
               end
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.granted !== want.granted || got.slot !== want.slot ||
                   got.tag !== want.tag || got.abort !== want.abort) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: mismatch", $realtime);
                     $display("  exp granted %0b slot %0d tag %0h abort %0b",
                              want.granted, want.slot, want.tag, want.abort);
                     $display("  got granted %0b slot %0d tag %0h abort %0b",
                              got.granted, got.slot, got.tag, got.abort);
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_rsp_q.push_back(predict_request(req_ch.action, req_ch.slot_index,
                                                     req_ch.retry_later));
      end
      pending <= expected_rsp_q.size();
   end

endmodule

### tb/tb_overwrite_oldest_slot_pool.sv
// Testbench top for the slot pool: clock, reset, request stimulus and the verdict.
// Depends on oosp_pkg, the channel interfaces, the block and oosp_checker.
`timescale 1ns / 100ps

module tb_overwrite_oldest_slot_pool;
   import oosp_pkg::*;

   localparam int SLOTS        = 8;
   localparam int RANDOM_ITEMS = 850;
   localparam int PHASES       = 4;
   localparam int TAIL_CYCLES  = SLOTS + 8;
   localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = ACTION_W'(ACT_RESTORE + 1);

   logic clock = 1'b0;
   logic reset;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int sent = 0;
   int pending, fail_count, checked, overwrites, refusals;

   oosp_req_if req_ch ();
   oosp_rsp_if rsp_ch ();

   overwrite_oldest_slot_pool #(.SLOT_COUNT(SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   oosp_checker #(.SLOT_COUNT(SLOTS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .pending    (pending),
      .fail_count (fail_count),
      .checked    (checked),
      .overwrites (overwrites),
      .refusals   (refusals)
   );

   always #10 clock = ~clock;

   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);

   // called at a rising edge; returns at the edge where the transaction is taken
   task automatic send_req(input logic [ACTION_W-1:0] act,
                           input logic [INDEX_W-1:0]  idx,
                           input logic                retry);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.slot_index  <= idx;
      req_ch.retry_later <= retry;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // mostly lifecycle traffic, a little junk
   function automatic logic [ACTION_W-1:0] random_action();
      int roll;
      roll = $urandom_range(99);
      if (roll < 30)      return ACT_RESERVE;
      else if (roll < 55) return ACT_MARK_READY;
      else if (roll < 73) return ACT_CLAIM;
      else if (roll < 85) return ACT_RESTORE;
      else if (roll < 97) return ACT_FREE;
      else                return ACTION_W'($urandom_range(2**ACTION_W - 1, ACT_FIRST_UNUSED));
   endfunction

   initial begin : stimulus
      logic [ACTION_W-1:0] junk;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.action      <= ACT_RESERVE;
      req_ch.slot_index  <= '0;
      req_ch.retry_later <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // equal tags after reset: lowest index wins the claim
      send_req(ACT_MARK_READY, 3'd6, 1'b1);
      send_req(ACT_MARK_READY, 3'd2, 1'b0);
      send_req(ACT_CLAIM,      3'd7, 1'b1);
      send_req(ACT_RESTORE,    3'd2, 1'b0);
      send_req(ACT_RESTORE,    3'd6, 1'b1);
      send_req(ACT_FREE,       3'd2, 1'b1);
      send_req(ACT_FREE,       3'd6, 1'b0);
      for (int i = 0; i < SLOTS; i++)
         send_req(ACT_RESERVE, INDEX_W'(SLOTS - 1 - i), i[0]);
      // full pool with nothing ready: both are refused
      send_req(ACT_RESERVE,    3'd0, 1'b0);
      send_req(ACT_CLAIM,      3'd0, 1'b0);
      // full pool: reserve overwrites the oldest ready slot
      send_req(ACT_MARK_READY, 3'd5, 1'b0);
      send_req(ACT_MARK_READY, 3'd1, 1'b1);
      send_req(ACT_RESERVE,    3'd3, 1'b1);
      send_req(ACT_FREE,       3'd7, 1'b0);
      send_req(ACT_RESERVE,    3'd0, 1'b0);
      junk = ACT_FIRST_UNUSED;
      repeat (2**ACTION_W - ACT_FIRST_UNUSED) begin
         send_req(junk, 3'd7, 1'b1);
         junk = junk + 1'b1;
      end
      drain_results();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 54; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 54; end
            default: begin send_idle_pct = 6; rsp_stall_pct = 6; end
         endcase
         repeat (RANDOM_ITEMS / PHASES)
            send_req(random_action(), INDEX_W'($urandom_range(SLOTS - 1)),
                     1'($urandom_range(1)));
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Summary: %0d requests over four handshake phases, %0d responses checked",
               sent, checked);
      $display("Summary: %0d reserves overwrote a ready slot, %0d requests found no slot",
               overwrites, refusals);
      if (fail_count == 0 && pending == 0) begin
         $display("** overwrite_oldest_slot_pool: PASSED **");
      end else begin
         $display("** overwrite_oldest_slot_pool: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Timeout with %0d responses outstanding", pending);
      $display("** overwrite_oldest_slot_pool: FAILED **");
      $finish;
   end

endmodule

### sim.f
design/oosp_pkg.sv
design/oosp_chan_if.sv
design/oosp_ctrl.sv
design/oosp_dp.sv
design/overwrite_oldest_slot_pool.sv
tb/oosp_checker.sv
tb/tb_overwrite_oldest_slot_pool.sv
